/* rtl/assert_macros.svh */
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpc check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define RPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpc check failed");

`endif

/* rtl/rpc_pkg.sv */
// Types and constants for the pose chain and point transform block.
`timescale 1ns / 1ps

package rpc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int WORD_W     = 32;
  localparam int PROD_W     = 2 * WORD_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int POSE_WORDS = 12;
  localparam int IDX_W      = 4;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [IDX_W-1:0]         idx_t;

  localparam word_t ONE_Q    = word_t'(64'(1) << FRAC_BITS);
  localparam word_t WORD_MAX = word_t'({1'b0, {(WORD_W-1){1'b1}}});
  localparam word_t WORD_MIN = word_t'({1'b1, {(WORD_W-1){1'b0}}});
  localparam sum_t  SUM_HALF = sum_t'(1) <<< (FRAC_BITS - 1);
  localparam sum_t  SUM_MAX  = sum_t'(WORD_MAX);
  localparam sum_t  SUM_MIN  = sum_t'(WORD_MIN);

  // last pose word; its arrival triggers the compose
  localparam idx_t POSE_LAST = idx_t'(POSE_WORDS - 1);

  typedef enum logic {
    CMD_POSE  = 1'b0,
    CMD_POINT = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t  command;
    idx_t  pose_index;
    logic  new_segment;
    logic  last_point;
    word_t x_in;
    word_t y_in;
    word_t z_in;
  } in_item_t;

  typedef struct packed {
    word_t x_out;
    word_t y_out;
    word_t z_out;
    logic  last_out;
    logic  overflow;
  } out_item_t;

endpackage

/* rtl/rpc_lane.sv */
// One row lane: three registered 32x32 products, rounded Q sum plus addend, saturation.
`timescale 1ns / 1ps

module rpc_lane (
  input  logic          clk,
  input  logic          ld,
  input  rpc_pkg::word_t a [3],
  input  rpc_pkg::word_t b [3],
  input  rpc_pkg::word_t addend,
  output rpc_pkg::word_t result,
  output logic          sat
);
  import rpc_pkg::*;

  prod_t prod [3];
  word_t add_q;
  sum_t  total;
  sum_t  scaled;

  always_ff @(posedge clk) begin
    if (ld) begin
      for (int i = 0; i < 3; i++) begin
        prod[i] <= prod_t'(a[i]) * prod_t'(b[i]);
      end
      add_q <= addend;
    end
  end

  // round half up: add half an LSB, then floor via arithmetic shift
  always_comb begin
    total  = sum_t'(prod[0]) + sum_t'(prod[1]) + sum_t'(prod[2])
           + (sum_t'(add_q) <<< FRAC_BITS) + SUM_HALF;
    scaled = total >>> FRAC_BITS;
    if (scaled > SUM_MAX) begin
      result = WORD_MAX;
      sat    = 1'b1;
    end else if (scaled < SUM_MIN) begin
      result = WORD_MIN;
      sat    = 1'b1;
    end else begin
      result = scaled[WORD_W-1:0];
      sat    = 1'b0;
    end
  end

endmodule

/* rtl/rigid_pose_chain_point_transform.sv */
// Pose chain and point transform: top level with the lanes, pose store and compose sequencer.
// Point path: stage 0 holds the point, the lanes its products, then the result register.
// Throughput: one point per cycle unless busy or stalled; pose words 0-10 cause no stall.
// The final pose word holds off input while the three row lanes
// are reused for four compose passes once queued points have drained.
// Reset (rst, synchronous): pipeline empty, accumulated pose identity, keyframe undefined.
`timescale 1ns / 1ps

module rigid_pose_chain_point_transform (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  rpc_pkg::in_item_t  cmd_item,
  output logic               res_valid,
  input  logic               res_stall,
  output rpc_pkg::out_item_t res_item
);
  import rpc_pkg::*;

  localparam logic [1:0] STEP_TRANS = 2'd3;

  word_t acc   [POSE_WORDS];
  word_t kf    [POSE_WORDS];
  word_t nxt_r [9];

  // stage 0: accepted point
  logic  s0_valid;
  logic  s0_last;
  word_t s0_x, s0_y, s0_z;

  // stage 1: products held inside the lanes
  logic       s1_valid;
  logic       s1_cmp;
  logic [1:0] s1_step;
  logic       s1_last;

  // compose sequencer
  logic       busy;
  logic       start;
  logic       issuing;
  logic       newseg_q;
  logic [1:0] step;

  logic  en0, en1, en2;
  logic  acc_in, pose_wr, last_wr, pt_acc;
  logic  issue, mv0, ld1, cmp_done;
  word_t lane_a [3][3];
  word_t lane_b [3];
  word_t lane_add [3];
  word_t lane_res [3];
  logic  lane_sat [3];

  always_comb begin
    en2      = !res_valid || !res_stall;
    en1      = !s1_valid || en2;
    en0      = !s0_valid || en1;
    cmd_stall = busy || !en0;
    acc_in   = cmd_valid && !cmd_stall;
    pose_wr  = acc_in && (cmd_item.command == CMD_POSE)
               && (cmd_item.pose_index < idx_t'(POSE_WORDS));
    last_wr  = pose_wr && (cmd_item.pose_index == POSE_LAST);
    pt_acc   = acc_in && (cmd_item.command == CMD_POINT);
    issue    = issuing && en1;
    mv0      = s0_valid && en1;
    ld1      = issue || mv0;
    cmp_done = s1_valid && s1_cmp && en2;
  end

  // operand selection: compose passes take a keyframe column, points take the point
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        lane_a[r][c] = acc[3*r + c];
      end
    end
    if (issuing) begin
      unique case (step)
        2'd0:       lane_b = '{kf[0], kf[3], kf[6]};
        2'd1:       lane_b = '{kf[1], kf[4], kf[7]};
        2'd2:       lane_b = '{kf[2], kf[5], kf[8]};
        STEP_TRANS: lane_b = '{kf[9], kf[10], kf[11]};
        default:    lane_b = '{kf[9], kf[10], kf[11]};
      endcase
    end else begin
      lane_b = '{s0_x, s0_y, s0_z};
    end
    for (int r = 0; r < 3; r++) begin
      lane_add[r] = (issuing && step != STEP_TRANS) ? '0 : acc[9 + r];
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_lane
    rpc_lane u_lane (
      .clk    (clk),
      .ld     (ld1),
      .a      (lane_a[r]),
      .b      (lane_b),
      .addend (lane_add[r]),
      .result (lane_res[r]),
      .sat    (lane_sat[r])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      s1_cmp    <= 1'b0;
      s1_step   <= '0;
      res_valid <= 1'b0;
      busy      <= 1'b0;
      start     <= 1'b0;
      issuing   <= 1'b0;
      newseg_q  <= 1'b0;
      step      <= '0;
      for (int i = 0; i < POSE_WORDS; i++) begin
        acc[i] <= (i == 0 || i == 4 || i == 8) ? ONE_Q : '0;
      end
    end else begin
      if (en0) begin
        s0_valid <= pt_acc;
      end
      if (en1) begin
        s1_valid <= ld1;
        s1_cmp   <= issue;
        s1_step  <= step;
      end
      if (en2) begin
        res_valid <= s1_valid && !s1_cmp;
      end
      if (last_wr) begin
        busy     <= 1'b1;
        start    <= 1'b1;
        newseg_q <= cmd_item.new_segment;
      end
      // wait for the last queued point to read the old pose before touching it
      if (start && !s0_valid) begin
        start   <= 1'b0;
        issuing <= 1'b1;
        step    <= '0;
        if (newseg_q) begin
          for (int i = 0; i < POSE_WORDS; i++) begin
            acc[i] <= (i == 0 || i == 4 || i == 8) ? ONE_Q : '0;
          end
        end
      end
      if (issue) begin
        step <= step + 2'd1;
        if (step == STEP_TRANS) begin
          issuing <= 1'b0;
        end
      end
      if (cmp_done && s1_step == STEP_TRANS) begin
        for (int i = 0; i < 9; i++) begin
          acc[i] <= nxt_r[i];
        end
        for (int r = 0; r < 3; r++) begin
          acc[9 + r] <= lane_res[r];
        end
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pose_wr) begin
      kf[cmd_item.pose_index] <= cmd_item.x_in;
    end
    if (en0 && pt_acc) begin
      s0_last <= cmd_item.last_point;
      s0_x    <= cmd_item.x_in;
      s0_y    <= cmd_item.y_in;
      s0_z    <= cmd_item.z_in;
    end
    if (en1) begin
      s1_last <= s0_last;
    end
    if (en2 && s1_valid && !s1_cmp) begin
      res_item.x_out    <= lane_res[0];
      res_item.y_out    <= lane_res[1];
      res_item.z_out    <= lane_res[2];
      res_item.last_out <= s1_last;
      res_item.overflow <= lane_sat[0] || lane_sat[1] || lane_sat[2];
    end
    // rotation columns wait here until the translation pass commits
    if (cmp_done) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (s1_step == 2'(c)) begin
            nxt_r[3*r + c] <= lane_res[r];
          end
        end
      end
    end
  end

  `include "assert_macros.svh"

  `RPC_ASSERT_NOW(a_busy_holds_input, busy, cmd_stall)
  `RPC_ASSERT_NOW(a_issue_after_drain, issuing, !s0_valid && busy)
  `RPC_ASSERT_NEXT(a_compose_no_result, cmp_done, !res_valid)
  `RPC_ASSERT_NEXT(a_commit_frees, cmp_done && s1_step == STEP_TRANS, !busy)

endmodule

/* tb/sv/tb_rigid_pose_chain_point_transform.sv */
// Testbench for the pose chain and point transform block: stimulus, predictor and checker.
`timescale 1ns / 1ps

module tb_rigid_pose_chain_point_transform;
  import rpc_pkg::*;

  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 20;

  // wide enough for three full 32x32 products plus the shifted bias
  typedef logic signed [79:0] wide_t;

  class point_map_board;
    word_t     map_pose[POSE_WORDS];
    word_t     key_pose[POSE_WORDS];
    out_item_t pending_points[$];
    int        errors;

    function new();
      errors = 0;
      load_identity();
      foreach (key_pose[i]) key_pose[i] = '0;
    endfunction

    function void load_identity();
      foreach (map_pose[i]) map_pose[i] = '0;
      map_pose[0] = ONE_Q;
      map_pose[4] = ONE_Q;
      map_pose[8] = ONE_Q;
    endfunction

    // exact dot product plus bias, round half up, clamp to 32 bits
    function word_t dot3(input word_t a0, a1, a2, b0, b1, b2, bias, output bit clipped);
      wide_t s;
      wide_t hi;
      wide_t lo;
      s = wide_t'(a0) * wide_t'(b0) + wide_t'(a1) * wide_t'(b1) + wide_t'(a2) * wide_t'(b2);
      s = s + (wide_t'(bias) <<< FRAC_BITS) + (wide_t'(1) <<< (FRAC_BITS - 1));
      s = s >>> FRAC_BITS;
      hi = wide_t'(WORD_MAX);
      lo = wide_t'(WORD_MIN);
      clipped = 1'b0;
      if (s > hi) begin
        clipped = 1'b1;
        return WORD_MAX;
      end
      if (s < lo) begin
        clipped = 1'b1;
        return WORD_MIN;
      end
      return word_t'(s);
    endfunction

    function void chain_keyframe();
      word_t nxt[POSE_WORDS];
      bit    dropped;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++)
          nxt[3*r+c] = dot3(map_pose[3*r], map_pose[3*r+1], map_pose[3*r+2],
                            key_pose[c], key_pose[3+c], key_pose[6+c], '0, dropped);
        nxt[9+r] = dot3(map_pose[3*r], map_pose[3*r+1], map_pose[3*r+2],
                        key_pose[9], key_pose[10], key_pose[11], map_pose[9+r], dropped);
      end
      map_pose = nxt;
    endfunction

    function void take_cmd(in_item_t it);
      out_item_t want;
      bit        clipped;
      word_t     v[3];
      if (it.command == CMD_POSE) begin
        if (it.pose_index < POSE_WORDS) begin
          key_pose[it.pose_index] = it.x_in;
          if (it.pose_index == POSE_LAST) begin
            if (it.new_segment) load_identity();
            chain_keyframe();
          end
        end
      end else begin
        want.overflow = 1'b0;
        for (int r = 0; r < 3; r++) begin
          v[r] = dot3(map_pose[3*r], map_pose[3*r+1], map_pose[3*r+2],
                      it.x_in, it.y_in, it.z_in, map_pose[9+r], clipped);
          want.overflow |= clipped;
        end
        want.x_out    = v[0];
        want.y_out    = v[1];
        want.z_out    = v[2];
        want.last_out = it.last_point;
        pending_points.push_back(want);
      end
    endfunction

    function void field_ok(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t %s mismatch: expected %h, actual %h", $time, what, want, got);
      end
    endfunction

    function void check_point(out_item_t got);
      out_item_t want;
      if (pending_points.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual %h", $time, got);
        return;
      end
      want = pending_points.pop_front();
      field_ok("x_out", want.x_out, got.x_out);
      field_ok("y_out", want.y_out, got.y_out);
      field_ok("z_out", want.z_out, got.z_out);
      field_ok("last_out", 32'(want.last_out), 32'(got.last_out));
      field_ok("overflow", 32'(want.overflow), 32'(got.overflow));
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  in_item_t  cmd_item = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  out_item_t res_item;

  point_map_board sb = new();
  int tx_idle_pct = 8;
  int rx_idle_pct = 68;
  int live_items  = 0;
  int hold_req    = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int cycles      = 0;

  rigid_pose_chain_point_transform uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[rigid_pose_chain_point_transform] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_point(res_item);
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left != 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic word_t rand_coord();
    case ($urandom_range(9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2, 3: return word_t'($urandom);
      default: return word_t'($urandom_range(32'h0200_0000) - 32'h0100_0000);
    endcase
  endfunction

  function automatic word_t rand_rot();
    case ($urandom_range(9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return word_t'($urandom);
      3: return '0;
      default: return word_t'($urandom_range(2 * ONE_Q) - ONE_Q);
    endcase
  endfunction

  function automatic in_item_t pose_item(idx_t idx, word_t val, logic seg);
    in_item_t it;
    it.command     = CMD_POSE;
    it.pose_index  = idx;
    it.new_segment = seg;
    it.last_point  = 1'($urandom_range(1));
    it.x_in        = val;
    it.y_in        = word_t'($urandom);
    it.z_in        = word_t'($urandom);
    return it;
  endfunction

  function automatic in_item_t point_item(word_t x, word_t y, word_t z, logic last);
    in_item_t it;
    it.command     = CMD_POINT;
    it.pose_index  = idx_t'($urandom_range(15));
    it.new_segment = 1'($urandom_range(1));
    it.last_point  = last;
    it.x_in        = x;
    it.y_in        = y;
    it.z_in        = z;
    return it;
  endfunction

  task automatic send_cmd(input in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_item  <= it;
    do @(posedge clk); while (cmd_stall);
    sb.take_cmd(it);
    if (it.command == CMD_POINT || it.pose_index < POSE_WORDS) live_items++;
  endtask

  task automatic send_keyframe(input logic seg);
    for (int i = 0; i < POSE_WORDS; i++) begin
      if ($urandom_range(19) == 0)
        send_cmd(pose_item(idx_t'($urandom_range(12, 15)), word_t'($urandom), 1'b0));
      // broken sequence: leave an old word in place
      if (i < POSE_WORDS - 1 && $urandom_range(11) == 0) continue;
      send_cmd(pose_item(idx_t'(i), (i < 9) ? rand_rot() : rand_coord(), seg));
    end
  endtask

  task automatic send_points(input int n);
    for (int i = 0; i < n; i++)
      send_cmd(point_item(rand_coord(), rand_coord(), rand_coord(), i == n - 1));
  endtask

  task automatic random_phase(input int upto);
    while (live_items < upto) begin
      if ($urandom_range(9) < 7) begin
        send_keyframe($urandom_range(2) == 0);
        send_points($urandom_range(1, 8));
      end else if ($urandom_range(1)) begin
        send_cmd(point_item(rand_coord(), rand_coord(), rand_coord(),
                            1'($urandom_range(1))));
      end else begin
        send_cmd(pose_item(idx_t'($urandom_range(15)), word_t'($urandom),
                           1'($urandom_range(1))));
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (sb.pending_points.size() != 0) @(negedge clk);
  endtask

  task automatic directed();
    word_t kf[POSE_WORDS];
    kf = '{WORD_MAX, WORD_MIN, '0, ONE_Q, -ONE_Q, ONE_Q, '0, WORD_MIN, WORD_MAX,
           WORD_MAX, WORD_MIN, '0};
    // identity pose: points pass through unchanged
    send_cmd(point_item(WORD_MAX, WORD_MIN, '0, 1'b1));
    send_cmd(point_item(WORD_MIN, WORD_MAX, word_t'(-1), 1'b0));
    send_cmd(point_item(ONE_Q, -ONE_Q, word_t'(1), 1'b1));
    // out-of-range word index is dropped
    send_cmd(pose_item(idx_t'(15), WORD_MAX, 1'b1));
    for (int i = 0; i < POSE_WORDS; i++)
      send_cmd(pose_item(idx_t'(i), kf[i], i == POSE_WORDS - 1));
    send_cmd(point_item(WORD_MAX, WORD_MAX, WORD_MAX, 1'b0));
    send_cmd(point_item(WORD_MIN, WORD_MIN, WORD_MIN, 1'b0));
    send_cmd(point_item('0, '0, '0, 1'b1));
    // chain onto the extreme pose: composition clamps
    send_cmd(pose_item(POSE_LAST, WORD_MIN, 1'b0));
    send_cmd(point_item(ONE_Q, ONE_Q, ONE_Q, 1'b1));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    directed();
    random_phase(470);
    wait_drained();
    tx_idle_pct = 68;
    rx_idle_pct = 8;
    random_phase(940);
    wait_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req++;
    random_phase(1400);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending_points.size() == 0)
      $display("[rigid_pose_chain_point_transform] OK");
    else
      $display("[rigid_pose_chain_point_transform] ERROR");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/rpc_pkg.sv
rtl/rpc_lane.sv
rtl/rigid_pose_chain_point_transform.sv
tb/sv/tb_rigid_pose_chain_point_transform.sv
